// ===== src/dpr_pkg.sv =====
// dpr_pkg: shared types and constants for the double pack and round pipeline.
// Used by double_pack_round_top, dpr_round_pack and dpr_checker; no dependencies.
package dpr_pkg;

	// Input class codes
	localparam logic [2:0] CLASS_NAN_A  = 3'd0;
	localparam logic [2:0] CLASS_NAN_B  = 3'd1;
	localparam logic [2:0] CLASS_ZERO   = 3'd2;
	localparam logic [2:0] CLASS_FINITE = 3'd3;
	localparam logic [2:0] CLASS_INF    = 3'd4;

	// Field widths
	localparam int unsigned MANT_W = 62;
	localparam int unsigned EXP_W  = 11;
	localparam int unsigned SH_W   = 6;
	localparam int unsigned WORD_W = 32;

	// Exponent limits and constants
	localparam logic signed [16:0] DENORM_EXP = -17'sd1022;
	localparam logic signed [16:0] MAX_EXP    = 17'sd1023;
	localparam logic signed [16:0] MAX_SHIFT  = 17'sd56;
	localparam logic [EXP_W-1:0]   EXP_BIAS   = 11'd1023;
	localparam logic [EXP_W-1:0]   EXP_ONES   = 11'h7ff;
	localparam logic [MANT_W-1:0]  QUIET_BIT  = 62'h0008_0000_0000_0000;

	// Rounding constants at the guard byte
	localparam logic [7:0] GUARD_HALF = 8'h80;
	localparam logic [7:0] GUARD_UP   = 8'h7f;

	// What the later stages have to do with an item
	typedef enum logic [2:0] {
		KIND_ZERO,
		KIND_NAN,
		KIND_INF,
		KIND_DENORM,
		KIND_NORMAL
	} kind_t;

	// Control that travels alongside the mantissa into rounding
	typedef struct packed {
		kind_t            kind;
		logic             sign;
		logic [EXP_W-1:0] ex;
	} ctl_t;

endpackage

// ===== src/double_pack_round_top.sv =====
// Throughput: one request per cycle while in_stall is low; stage 1 decodes the class and
// exponent, stage 2 does the denormal barrel shift with sticky, stage 3 rounds and packs
// into the output register.
// Reset (arst_n low, asynchronous) clears all stage valid bits; payload is not reset.
// Stall on the input rises only when every stage is full and the output is stalled.
// Depends on dpr_pkg and dpr_round_pack.
module double_pack_round_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    num_class,
	input  logic                          sign_bit,
	input  logic signed [15:0]            unbiased_exp,
	input  logic [dpr_pkg::MANT_W-1:0]    mantissa,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dpr_pkg::WORD_W-1:0]    high_word,
	output logic [dpr_pkg::WORD_W-1:0]    low_word
);

	// Stage valid bits and handshake
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3     = !v_s3 || !out_stall;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// Stage 1: classify, denormal shift amount, biased exponent
	logic signed [16:0]             exp_wide;
	logic signed [16:0]             sh_full;
	dpr_pkg::kind_t                 kind_d;
	dpr_pkg::ctl_t                  ctl_s1;
	logic [dpr_pkg::SH_W-1:0]       sh_s1;
	logic [dpr_pkg::MANT_W-1:0]     mant_s1;

	assign exp_wide = 17'(unbiased_exp);
	assign sh_full  = dpr_pkg::DENORM_EXP - exp_wide;

	always_comb begin
		unique case (num_class)
			dpr_pkg::CLASS_NAN_A, dpr_pkg::CLASS_NAN_B: kind_d = dpr_pkg::KIND_NAN;
			dpr_pkg::CLASS_ZERO: kind_d = dpr_pkg::KIND_ZERO;
			dpr_pkg::CLASS_INF:  kind_d = dpr_pkg::KIND_INF;
			default: begin
				// finite number, and the unused codes behave the same
				priority if (mantissa == '0) begin
					kind_d = dpr_pkg::KIND_ZERO;
				end else if (exp_wide < dpr_pkg::DENORM_EXP) begin
					kind_d = (sh_full > dpr_pkg::MAX_SHIFT) ? dpr_pkg::KIND_ZERO
					                                        : dpr_pkg::KIND_DENORM;
				end else if (exp_wide > dpr_pkg::MAX_EXP) begin
					kind_d = dpr_pkg::KIND_INF;
				end else begin
					kind_d = dpr_pkg::KIND_NORMAL;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			ctl_s1.kind <= kind_d;
			ctl_s1.sign <= sign_bit;
			ctl_s1.ex   <= unbiased_exp[10:0] + dpr_pkg::EXP_BIAS;
			sh_s1       <= sh_full[dpr_pkg::SH_W-1:0];
			mant_s1     <= mantissa;
		end
	end

	// Stage 2: denormal right shift with sticky, quiet bit for NaN
	logic [dpr_pkg::MANT_W-1:0] sticky_mask;
	logic [dpr_pkg::MANT_W-1:0] mant_d2;
	dpr_pkg::ctl_t              ctl_s2;
	logic [dpr_pkg::MANT_W-1:0] mant_s2;

	assign sticky_mask = (62'd1 << sh_s1) - 62'd1;

	always_comb begin
		unique case (ctl_s1.kind)
			dpr_pkg::KIND_DENORM: begin
				mant_d2 = (mant_s1 >> sh_s1)
				        | {61'd0, |(mant_s1 & sticky_mask)};
			end
			dpr_pkg::KIND_NAN:    mant_d2 = mant_s1 | dpr_pkg::QUIET_BIT;
			default:              mant_d2 = mant_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ctl_s2  <= ctl_s1;
			mant_s2 <= mant_d2;
		end
	end

	// Stage 3: round, renormalize, pack into the output register
	logic [dpr_pkg::WORD_W-1:0] high_d;
	logic [dpr_pkg::WORD_W-1:0] low_d;
	logic [dpr_pkg::WORD_W-1:0] high_s3;
	logic [dpr_pkg::WORD_W-1:0] low_s3;

	dpr_round_pack u_round_pack (
		.ctl       (ctl_s2),
		.mant      (mant_s2),
		.high_word (high_d),
		.low_word  (low_d)
	);

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			high_s3 <= high_d;
			low_s3  <= low_d;
		end
	end

	assign high_word = high_s3;
	assign low_word  = low_s3;

endmodule

// ===== src/dpr_round_pack.sv =====
// dpr_round_pack: round to nearest even at the guard byte, renormalize, pack words.
// Depends on dpr_pkg.
module dpr_round_pack (
	input  dpr_pkg::ctl_t                    ctl,
	input  logic [dpr_pkg::MANT_W-1:0]       mant,
	output logic [dpr_pkg::WORD_W-1:0]       high_word,
	output logic [dpr_pkg::WORD_W-1:0]       low_word
);

	logic [7:0]                  add_amt;
	logic [63:0]                 rnd;
	logic [dpr_pkg::EXP_W-1:0]   ex;
	logic [51:0]                 frac;

	// Guard byte increment: exact half rounds up only on odd lsb
	always_comb begin
		if (mant[7:0] == dpr_pkg::GUARD_HALF) begin
			add_amt = mant[8] ? dpr_pkg::GUARD_HALF : 8'h00;
		end else begin
			add_amt = dpr_pkg::GUARD_UP;
		end
	end

	assign rnd = {2'b00, mant} + {56'd0, add_amt};

	// Select exponent and fraction by kind
	always_comb begin
		unique case (ctl.kind)
			dpr_pkg::KIND_NAN: begin
				ex   = dpr_pkg::EXP_ONES;
				frac = mant[51:0];
			end
			dpr_pkg::KIND_INF: begin
				ex   = dpr_pkg::EXP_ONES;
				frac = '0;
			end
			dpr_pkg::KIND_DENORM: begin
				// carry into bit 60 turns the denormal into the smallest normal
				ex   = (rnd[63:60] != 4'd0) ? 11'd1 : 11'd0;
				frac = rnd[59:8];
			end
			dpr_pkg::KIND_NORMAL: begin
				if (rnd[63:61] != 3'd0) begin
					ex   = ctl.ex + 11'd1;
					frac = rnd[60:9];
				end else begin
					ex   = ctl.ex;
					frac = rnd[59:8];
				end
			end
			default: begin
				ex   = '0;
				frac = '0;
			end
		endcase
	end

	assign high_word = {ctl.sign, ex, frac[51:32]};
	assign low_word  = frac[31:0];

endmodule

// ===== src/dpr_checker.sv =====
// dpr_checker: port-level assertions for double_pack_round_top, bound to it below.
// Depends on dpr_pkg.
module dpr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [2:0]                    num_class,
	input logic                          sign_bit,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [dpr_pkg::WORD_W-1:0]    high_word,
	input logic [dpr_pkg::WORD_W-1:0]    low_word
);

	// Input stalls only when the result register is full and held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output not backed up");

	// A request with a free-running output passes all stages and shows up at out_valid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing after three cycles");

	// The sign passes through untouched
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall
		|=> (high_word[31] == $past(sign_bit, 3)))
		else $error("sign bit corrupted");

	// Infinity class packs to all-ones exponent and zero fraction
	a_inf: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && num_class == dpr_pkg::CLASS_INF)
		##1 !out_stall ##1 !out_stall
		|=> (high_word[30:0] == 31'h7ff0_0000 && low_word == '0))
		else $error("infinity packed wrong");

	// Held result does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(high_word)
		&& $stable(low_word)))
		else $error("stalled result changed");

endmodule

bind double_pack_round_top dpr_checker u_dpr_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for double_pack_round_top: packing and round-to-nearest-even of unpacked doubles.
// Needs dpr_pkg and the double_pack_round_top RTL; self-checking, no files or arguments.
module testbench;

	typedef logic [dpr_pkg::MANT_W-1:0] mant_t;
	typedef logic [dpr_pkg::EXP_W-1:0]  exp_field_t;

	// Unused class codes, handled as finite numbers
	localparam logic [2:0] CLASS_SPARE_LO  = 3'd5;
	localparam logic [2:0] CLASS_SPARE_MID = 3'd6;
	localparam logic [2:0] CLASS_SPARE_HI  = 3'd7;

	localparam mant_t IMPLICIT_ONE = 62'h1000_0000_0000_0000;
	localparam mant_t BELOW_TWO    = 62'h1FFF_FFFF_FFFF_FFFF;
	localparam mant_t MANT_ONES    = '1;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 100;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [2:0]        cls;
		logic              sgn;
		logic signed [15:0] e;
		mant_t             m;
	} pack_req_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [2:0]          num_class = dpr_pkg::CLASS_ZERO;
	logic                sign_bit = 1'b0;
	logic signed [15:0]  unbiased_exp = '0;
	mant_t               mantissa = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [dpr_pkg::WORD_W-1:0] high_word;
	logic [dpr_pkg::WORD_W-1:0] low_word;

	pack_req_t   pending_reqs[$];
	logic [63:0] expected_doubles[$];
	pack_req_t   next_req;
	logic [63:0] want;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_requests = 0;
	int          hold_seen;
	int          hold_left;
	int          errors = 0;
	int          cycle_count = 0;

	double_pack_round_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.num_class    (num_class),
		.sign_bit     (sign_bit),
		.unbiased_exp (unbiased_exp),
		.mantissa     (mantissa),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.high_word    (high_word),
		.low_word     (low_word)
	);

	always #5 clk = ~clk;

	// Round to nearest, ties to even, at the low guard byte
	function automatic logic [63:0] round_even_at_guard(logic [63:0] f);
		if (f[7:0] == dpr_pkg::GUARD_HALF) begin
			if (f[8])
				f = f + 64'(dpr_pkg::GUARD_HALF);
		end else begin
			f = f + 64'(dpr_pkg::GUARD_UP);
		end
		return f;
	endfunction

	// Expected packed double: {high_word, low_word}
	function automatic logic [63:0] pack_double(logic [2:0] cls, logic sgn,
			logic signed [15:0] e, mant_t m);
		logic [63:0] f;
		exp_field_t ex;
		int ei;
		int sh;
		logic [63:0] mask;
		f = {2'b00, m};
		ex = '0;
		ei = e;
		if (cls == dpr_pkg::CLASS_NAN_A || cls == dpr_pkg::CLASS_NAN_B) begin
			ex = dpr_pkg::EXP_ONES;
			f = f | {2'b00, dpr_pkg::QUIET_BIT};
		end else if (cls == dpr_pkg::CLASS_INF) begin
			ex = dpr_pkg::EXP_ONES;
			f = '0;
		end else if (cls == dpr_pkg::CLASS_ZERO) begin
			f = '0;
		end else if (f != 0) begin
			if (ei < -1022) begin
				// denormal: shift right with sticky, flush on a huge shift
				sh = -1022 - ei;
				if (sh > 56) begin
					f = '0;
				end else begin
					mask = (64'd1 << sh) - 64'd1;
					f = (f >> sh) | 64'((f & mask) != 0);
				end
				f = round_even_at_guard(f);
				if (f[63:32] > 32'h0FFF_FFFF)
					ex = 11'd1;
				f = f >> 8;
			end else if (ei > 1023) begin
				ex = dpr_pkg::EXP_ONES;
				f = '0;
			end else begin
				ex = exp_field_t'(ei + 1023);
				f = round_even_at_guard(f);
				// rounding carry renormalizes
				if (f[63:32] > 32'h1FFF_FFFF) begin
					f = f >> 1;
					ex = ex + 11'd1;
				end
				f = f >> 8;
			end
		end
		return {sgn, ex, f[51:32], f[31:0]};
	endfunction

	task automatic add_req(logic [2:0] cls, logic sgn, int e, mant_t m);
		pack_req_t r;
		r.cls = cls;
		r.sgn = sgn;
		r.e = 16'(e);
		r.m = m;
		pending_reqs.push_back(r);
	endtask

	// Random request, weighted toward finite numbers near the interesting exponents
	task automatic add_random_req();
		int pick;
		logic [2:0] cls;
		int e;
		mant_t m;
		pick = $urandom_range(99);
		if (pick < 5)
			cls = $urandom_range(1) ? dpr_pkg::CLASS_NAN_B : dpr_pkg::CLASS_NAN_A;
		else if (pick < 8)
			cls = dpr_pkg::CLASS_ZERO;
		else if (pick < 11)
			cls = dpr_pkg::CLASS_INF;
		else if (pick < 14)
			cls = 3'($urandom_range(CLASS_SPARE_HI, CLASS_SPARE_LO));
		else
			cls = dpr_pkg::CLASS_FINITE;
		case ($urandom_range(9))
			0, 1, 2, 3: e = $urandom_range(2046) - 1023;
			4:          e = $urandom_range(1030, 1018);
			5, 6:       e = -$urandom_range(1085, 1015);
			7:          e = $urandom_range(65535);
			8:          e = -$urandom_range(1026, 1018);
			default:    e = -$urandom_range(1079, 1022);
		endcase
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				m = IMPLICIT_ONE | mant_t'({$urandom, $urandom} & 64'h0FFF_FFFF_FFFF_FFFF);
				case ($urandom_range(5))
					0: m[7:0] = dpr_pkg::GUARD_HALF;
					1: m[7:0] = dpr_pkg::GUARD_UP;
					2: m[7:0] = 8'hff;
					default: ;
				endcase
			end
			6:       m = BELOW_TWO - mant_t'($urandom_range(255));
			7:       m = mant_t'({$urandom, $urandom});
			8:       m = mant_t'($urandom_range(1 << 20));
			default: m = '0;
		endcase
		add_req(cls, 1'($urandom_range(1)), e, m);
	endtask

	// Wait until every request is accepted and every result has come back
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_doubles.size() != 0)
			@(negedge clk);
	endtask

	// Request driver: pops the pending queue, holds the payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			num_class <= dpr_pkg::CLASS_ZERO;
			sign_bit <= 1'b0;
			unbiased_exp <= '0;
			mantissa <= '0;
		end else begin
			if (in_valid && !in_stall)
				expected_doubles.push_back(pack_double(num_class, sign_bit, unbiased_exp,
					mantissa));
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_reqs.pop_front();
					num_class <= next_req.cls;
					sign_bit <= next_req.sgn;
					unbiased_exp <= next_req.e;
					mantissa <= next_req.m;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output stall: random back-pressure, plus a long hold when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_doubles.size() == 0) begin
				$display("%0t: unexpected result high %h low %h", $time, high_word, low_word);
				errors++;
			end else begin
				want = expected_doubles.pop_front();
				if (high_word !== want[63:32]) begin
					$display("%0t: high_word expected %h actual %h", $time, want[63:32],
						high_word);
					errors++;
				end
				if (low_word !== want[31:0]) begin
					$display("%0t: low_word expected %h actual %h", $time, want[31:0],
						low_word);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** double_pack_round_top: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Phase 0: sender idles a little, receiver a lot
		send_idle_pct = 36;
		recv_idle_pct = 87;
		add_req(dpr_pkg::CLASS_NAN_A, 1'b0, 0, '0);
		add_req(dpr_pkg::CLASS_NAN_B, 1'b1, -32768, MANT_ONES);
		add_req(dpr_pkg::CLASS_ZERO, 1'b1, 100, IMPLICIT_ONE | 62'h1234);
		add_req(dpr_pkg::CLASS_INF, 1'b0, 0, IMPLICIT_ONE);
		add_req(CLASS_SPARE_LO, 1'b0, 0, IMPLICIT_ONE);
		add_req(CLASS_SPARE_HI, 1'b1, -1, IMPLICIT_ONE | 62'hff);
		add_req(dpr_pkg::CLASS_FINITE, 1'b0, 5, '0);
		// carry out of the top exponent gives infinity
		add_req(dpr_pkg::CLASS_FINITE, 1'b0, 1023, BELOW_TWO);
		add_req(dpr_pkg::CLASS_FINITE, 1'b1, 1024, IMPLICIT_ONE);
		add_req(dpr_pkg::CLASS_FINITE, 1'b0, 32767, MANT_ONES);
		add_req(dpr_pkg::CLASS_FINITE, 1'b1, -32768, MANT_ONES);
		add_req(dpr_pkg::CLASS_FINITE, 1'b0, -1022, IMPLICIT_ONE);
		// denormal that rounds up into exponent one
		add_req(dpr_pkg::CLASS_FINITE, 1'b0, -1023, BELOW_TWO);
		add_req(dpr_pkg::CLASS_FINITE, 1'b1, -1078, MANT_ONES);
		add_req(dpr_pkg::CLASS_FINITE, 1'b0, -1079, MANT_ONES);
		// ties: even stays, odd rounds up
		add_req(dpr_pkg::CLASS_FINITE, 1'b0, 0, IMPLICIT_ONE | 62'h080);
		add_req(dpr_pkg::CLASS_FINITE, 1'b0, 0, IMPLICIT_ONE | 62'h180);
		add_req(dpr_pkg::CLASS_FINITE, 1'b1, 0, IMPLICIT_ONE | 62'h07f);
		add_req(dpr_pkg::CLASS_FINITE, 1'b1, 0, IMPLICIT_ONE | 62'h081);
		// unnormalized mantissas, small and with bit 61 set
		add_req(dpr_pkg::CLASS_FINITE, 1'b0, 10, 62'h12345);
		add_req(dpr_pkg::CLASS_FINITE, 1'b1, 100, 62'h3000_0000_0000_00ff);
		add_req(dpr_pkg::CLASS_FINITE, 1'b0, -1030, IMPLICIT_ONE | 62'h8000);
		add_req(CLASS_SPARE_MID, 1'b1, -1022, MANT_ONES);
		repeat (420) add_random_req();
		wait_drained();

		// Phase 1: the other way round
		send_idle_pct = 87;
		recv_idle_pct = 36;
		repeat (430) add_random_req();
		wait_drained();

		// Phase 2: no idling; a long output hold fills the pipeline first
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = hold_requests + 1;
		repeat (430) add_random_req();
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("** double_pack_round_top: PASSED **");
		else
			$display("** double_pack_round_top: FAILED **");
		$finish;
	end

endmodule
